// ===== hw/rtl/ipr_pkg.sv =====
// ----------------------------------------------------------------------------
// ipr_pkg
// Shared constants, codes and types of the integer pixel replication upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ipr_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_SCALE  = 100;

	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W    = ADDR_W + 1;
	localparam int SCALE_W    = 7;
	localparam int COLOR_W    = 8;
	localparam int PAD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = CFG_IDX_W'(1);

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_PULL  = 1'b1;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              row_end;
		logic              group_end;
		logic [PAD_W-1:0]  pad;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ipr_line_ram.sv =====
// ----------------------------------------------------------------------------
// ipr_line_ram
// Line store: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_line_ram (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ipr_pkg::ADDR_W-1:0]  wr_addr,
	input  wire ipr_pkg::pixel_t             wr_data,
	input  wire logic                        rd_en,
	input  wire logic [ipr_pkg::ADDR_W-1:0]  rd_addr,
	output ipr_pkg::pixel_t                  rd_data_s1
);

	ipr_pkg::pixel_t mem [ipr_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ipr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipr_ctrl
// Configuration registers, line fill and replay counters, and the per-item
// store and pull decisions with the row and group end flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire logic                            op,
	input  wire logic                            cfg_we,
	input  wire logic [ipr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ipr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ipr_pkg::ctrl_t                       ctrl
);

	logic [ipr_pkg::SCALE_W-1:0] scale_q;
	logic [ipr_pkg::WIDTH_W-1:0] width_q;
	logic [ipr_pkg::ADDR_W-1:0]  wr_col_q;
	logic [ipr_pkg::ADDR_W-1:0]  rd_col_q;
	logic [ipr_pkg::SCALE_W-1:0] h_rep_q;
	logic [ipr_pkg::SCALE_W-1:0] v_rep_q;
	logic                        ready_q;

	logic [ipr_pkg::SCALE_W-1:0] scale_in;
	logic [ipr_pkg::WIDTH_W-1:0] width_in;
	logic [ipr_pkg::WIDTH_W-1:0] wr_col_inc;
	logic [ipr_pkg::WIDTH_W-1:0] rd_col_inc;
	logic [ipr_pkg::SCALE_W:0]   h_rep_inc;
	logic [ipr_pkg::SCALE_W:0]   v_rep_inc;
	logic                        wr_last;
	logic                        col_last;
	logic                        h_last;
	logic                        v_last;
	logic                        do_store;
	logic                        do_pull;
	logic [3:0]                  pad_prod;

	always_comb begin
		scale_in = cfg_data[ipr_pkg::SCALE_W-1:0];
		if (scale_in == '0) begin
			scale_in = ipr_pkg::SCALE_W'(1);
		end else if (scale_in > ipr_pkg::SCALE_W'(ipr_pkg::MAX_SCALE)) begin
			scale_in = ipr_pkg::SCALE_W'(ipr_pkg::MAX_SCALE);
		end
		width_in = cfg_data[ipr_pkg::WIDTH_W-1:0];
		if (width_in == '0) begin
			width_in = ipr_pkg::WIDTH_W'(1);
		end else if (width_in > ipr_pkg::WIDTH_W'(ipr_pkg::MAX_WIDTH)) begin
			width_in = ipr_pkg::WIDTH_W'(ipr_pkg::MAX_WIDTH);
		end
	end

	assign wr_col_inc = ipr_pkg::WIDTH_W'({1'b0, wr_col_q}) + ipr_pkg::WIDTH_W'(1);
	assign rd_col_inc = ipr_pkg::WIDTH_W'({1'b0, rd_col_q}) + ipr_pkg::WIDTH_W'(1);
	assign h_rep_inc  = {1'b0, h_rep_q} + (ipr_pkg::SCALE_W+1)'(1);
	assign v_rep_inc  = {1'b0, v_rep_q} + (ipr_pkg::SCALE_W+1)'(1);

	assign wr_last  = wr_col_inc >= width_q;
	assign col_last = rd_col_inc >= width_q;
	assign h_last   = h_rep_inc >= {1'b0, scale_q};
	assign v_last   = v_rep_inc >= {1'b0, scale_q};

	assign do_store = accept && (op == ipr_pkg::OP_STORE) && !ready_q;
	assign do_pull  = accept && (op == ipr_pkg::OP_PULL) && ready_q;

	// The pad count (4 - 3*w*n mod 4) mod 4 equals w*n mod 4.
	assign pad_prod = {2'b00, width_q[1:0]} * {2'b00, scale_q[1:0]};

	always_comb begin
		ctrl.wr_en     = do_store;
		ctrl.wr_addr   = wr_col_q;
		ctrl.rd_en     = do_pull;
		ctrl.rd_addr   = rd_col_q;
		ctrl.row_end   = col_last && h_last;
		ctrl.group_end = col_last && h_last && v_last;
		ctrl.pad       = (col_last && h_last) ? pad_prod[ipr_pkg::PAD_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= ipr_pkg::SCALE_W'(1);
			width_q  <= ipr_pkg::WIDTH_W'(1);
			wr_col_q <= '0;
			rd_col_q <= '0;
			h_rep_q  <= '0;
			v_rep_q  <= '0;
			ready_q  <= 1'b0;
		end else if (cfg_we) begin
			// A write to the scale or width register abandons the line in progress.
			if (cfg_index == ipr_pkg::CFG_SCALE) begin
				scale_q <= scale_in;
			end
			if (cfg_index == ipr_pkg::CFG_WIDTH) begin
				width_q <= width_in;
			end
			if (cfg_index == ipr_pkg::CFG_SCALE || cfg_index == ipr_pkg::CFG_WIDTH) begin
				wr_col_q <= '0;
				rd_col_q <= '0;
				h_rep_q  <= '0;
				v_rep_q  <= '0;
				ready_q  <= 1'b0;
			end
		end else if (do_store) begin
			if (wr_last) begin
				wr_col_q <= '0;
				ready_q  <= 1'b1;
				rd_col_q <= '0;
				h_rep_q  <= '0;
				v_rep_q  <= '0;
			end else begin
				wr_col_q <= wr_col_inc[ipr_pkg::ADDR_W-1:0];
			end
		end else if (do_pull) begin
			if (h_last) begin
				h_rep_q <= '0;
				if (col_last) begin
					rd_col_q <= '0;
					if (v_last) begin
						v_rep_q <= '0;
						ready_q <= 1'b0;
					end else begin
						v_rep_q <= v_rep_inc[ipr_pkg::SCALE_W-1:0];
					end
				end else begin
					rd_col_q <= rd_col_inc[ipr_pkg::ADDR_W-1:0];
				end
			end else begin
				h_rep_q <= h_rep_inc[ipr_pkg::SCALE_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_pixel_replication_upscaler.sv =====
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbor integer upscaler for 24-bit pixels with a line store.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one word per item: op 0
// stores a source pixel, op 1 pulls the next output pixel. Once source_width
// pixels are stored, pulls replay the line scale_factor times with every
// pixel repeated scale_factor times; stores during replay are dropped, and a
// pull with no line ready gives no word. The output channel (out_valid,
// out_stall) carries the pixel with row_end, group_end and pad_bytes.
// The configuration channel (cfg_valid, cfg_ready) is always ready; a write
// to scale or width clears the line in progress. Writes must be made only
// while the block is idle; the block itself does not enforce this. One item
// is accepted per cycle while in_stall is low. A pull's result passes through
// the registered line store read and then the output register.
// When the receiver stalls, the output word holds and one more result waits
// in the read stage; input is stalled only when both are full.
// Reset clears all counters, sets scale and width to one and empties the
// pipeline; line store contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pixel_replication_upscaler (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            op,
	input  wire logic [ipr_pkg::COLOR_W-1:0]     blue_in,
	input  wire logic [ipr_pkg::COLOR_W-1:0]     green_in,
	input  wire logic [ipr_pkg::COLOR_W-1:0]     red_in,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [ipr_pkg::COLOR_W-1:0]          blue_out,
	output logic [ipr_pkg::COLOR_W-1:0]          green_out,
	output logic [ipr_pkg::COLOR_W-1:0]          red_out,
	output logic [ipr_pkg::PAD_W-1:0]            pad_bytes,
	output logic                                 row_end,
	output logic                                 group_end,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ipr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ipr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	ipr_pkg::ctrl_t            ctrl;
	ipr_pkg::pixel_t           wr_pix;
	ipr_pkg::pixel_t           rd_pix_s1;
	logic                      accept;
	logic                      advance;
	logic                      valid_s1;
	logic                      row_end_s1;
	logic                      group_end_s1;
	logic [ipr_pkg::PAD_W-1:0] pad_s1;
	logic                      out_valid_q;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;

	assign wr_pix.red   = red_in;
	assign wr_pix.green = green_in;
	assign wr_pix.blue  = blue_in;

	ipr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl)
	);

	ipr_line_ram u_ram (
		.clk        (clk),
		.wr_en      (ctrl.wr_en),
		.wr_addr    (ctrl.wr_addr),
		.wr_data    (wr_pix),
		.rd_en      (ctrl.rd_en),
		.rd_addr    (ctrl.rd_addr),
		.rd_data_s1 (rd_pix_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= ctrl.rd_en;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			row_end_s1   <= ctrl.row_end;
			group_end_s1 <= ctrl.group_end;
			pad_s1       <= ctrl.pad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			blue_out  <= rd_pix_s1.blue;
			green_out <= rd_pix_s1.green;
			red_out   <= rd_pix_s1.red;
			pad_bytes <= pad_s1;
			row_end   <= row_end_s1;
			group_end <= group_end_s1;
		end
	end

	assign out_valid = out_valid_q;

	a_pad_only_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_end |-> pad_bytes == '0)
		else $error("pad bytes on a pixel that does not end a row");

	a_group_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && group_end |-> row_end)
		else $error("group end without row end");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled while the pipeline has room");

	a_stalled_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |=> valid_s1)
		else $error("waiting result dropped from the read stage");

endmodule

`default_nettype wire
